// ===== rtl/afs_pkg.sv =====
// Shared types and constants for the animation frame sequencer.
package afs_pkg;

	localparam int DEF_MAX_FRAMES = 256;
	localparam int DEF_MAX_STEPS  = 64;

	localparam int BANK_W     = 32;
	localparam int DELAY_W    = 20;
	localparam int ELAPSED_W  = 24;
	localparam int FCOUNT_W   = 9;
	localparam int FRAC_BITS  = 4;

	localparam logic [DELAY_W-1:0] MIN_DELAY_MS     = DELAY_W'(10);
	localparam logic [DELAY_W-1:0] DEFAULT_DELAY_MS = DELAY_W'(100);

	typedef enum logic [2:0] {
		OP_WRITE_DELAY = 3'd0,
		OP_RESTART     = 3'd1,
		OP_UPLOADED    = 3'd2,
		OP_TICK        = 3'd3,
		OP_RELEASE     = 3'd4
	} op_t;

	// one frame step: does the bank cover the delay, and what is left
	typedef struct packed {
		logic              hit;
		logic [BANK_W-1:0] bank_rem;
	} step_res_t;

endpackage

// ===== rtl/afs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module afs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/afs_step.sv =====
// Frame step datapath: bank versus scaled delay, subtract, wrapped next frame.
module afs_step #(
	parameter int MAX_FRAMES = afs_pkg::DEF_MAX_FRAMES
) (
	input  logic [afs_pkg::BANK_W-1:0]        bank,
	input  logic [afs_pkg::DELAY_W-1:0]       delay,
	input  logic [$clog2(MAX_FRAMES)-1:0]     frame,
	input  logic [$clog2(MAX_FRAMES+1)-1:0]   count,
	output afs_pkg::step_res_t                res,
	output logic [$clog2(MAX_FRAMES)-1:0]     frame_next
);
	import afs_pkg::*;

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);

	logic [BANK_W-1:0] need;
	logic [CW-1:0]     inc;

	assign need = BANK_W'(delay) << FRAC_BITS;
	assign res.hit      = (bank >= need);
	assign res.bank_rem = bank - need;

	assign inc        = CW'(frame) + CW'(1);
	assign frame_next = (inc >= count) ? '0 : inc[FW-1:0];

endmodule

// ===== rtl/animation_frame_sequencer_core.sv =====
// Animation frame sequencer top level: control sequencer, delay RAM, step unit.
//
// Usage: an item (operation plus fields) is taken at a clock edge with start
// high and busy low. Each item yields one result on shown_frame, upload_needed
// and frames_advanced, valid for the single cycle in which done is high; the
// receiver cannot hold it off.
// The frame_count register is written through cfg_valid/cfg_ready/cfg_data
// (cfg_ready is always high); write it only while the block is idle.
// Sequence: an execute state follows the accept. Non-tick items and ticks that
// do not animate finish there, done is registered from that finish, and the
// next item can be taken in the done cycle.
// An animating tick walks the delay RAM one frame per cycle; the RAM address
// runs one frame ahead so the registered read is hidden. The walk ends when the
// bank cannot cover a delay or after MAX_STEPS_PER_TICK steps (64 by default).
// Reset (arst_n low) clears frame, bank, upload marks and texture flag and sets
// frame_count to 1. The delay RAM is not cleared.
module animation_frame_sequencer_core #(
	parameter int MAX_FRAMES         = afs_pkg::DEF_MAX_FRAMES,
	parameter int MAX_STEPS_PER_TICK = afs_pkg::DEF_MAX_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    frame_index,
	input  logic                          delay_given,
	input  logic [afs_pkg::DELAY_W-1:0]   delay_ms,
	input  logic [afs_pkg::ELAPSED_W-1:0] elapsed_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afs_pkg::FCOUNT_W-1:0]  cfg_data,
	output logic                          done,
	output logic [7:0]                    shown_frame,
	output logic                          upload_needed,
	output logic [6:0]                    frames_advanced
);
	import afs_pkg::*;

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int SW = $clog2(MAX_STEPS_PER_TICK + 1);
	localparam logic [SW-1:0] LAST_STEP = SW'(MAX_STEPS_PER_TICK - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOP
	} state_t;

	state_t state_q, state_n;

	// captured transaction
	logic [2:0]           op_q;
	logic [7:0]           idx_q;
	logic                 given_q;
	logic [DELAY_W-1:0]   dms_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	// playback state
	logic [FW-1:0]       cur_q, cur_n;
	logic [BANK_W-1:0]   bank_q, bank_n;
	logic [FW-1:0]       upl_frame_q, upl_frame_n;
	logic                upl_valid_q, upl_valid_n;
	logic                tex_q, tex_n;
	logic [SW-1:0]       steps_q, steps_n;
	logic [FCOUNT_W-1:0] fcount_q;

	logic                done_q;
	logic [7:0]          shown_q;
	logic                need_q;
	logic [6:0]          adv_q;

	logic                finish;
	logic                accept;
	logic [CW-1:0]       count;
	logic                animate;
	logic [FW-1:0]       frame0;
	logic [BANK_W:0]     bank_sum;
	logic [BANK_W-1:0]   bank_sat;
	logic                idx_ok;
	logic [DELAY_W-1:0]  delay_wr;
	logic [FW-1:0]       raddr;
	logic [FW-1:0]       waddr;
	logic                we;
	logic [DELAY_W-1:0]  rdata;
	step_res_t           step;
	logic [FW-1:0]       frame_next;
	logic [31:0]         cur_ext;
	logic [31:0]         steps_ext;
	logic [31:0]         idx_ext;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// count saturated to the table size
	assign count = ({23'd0, fcount_q} > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fcount_q);
	assign animate = tex_q && (count > CW'(1));
	assign frame0  = (CW'(cur_q) >= count) ? '0 : cur_q;

	assign bank_sum = {1'b0, bank_q} + (BANK_W + 1)'(elapsed_q);
	assign bank_sat = bank_sum[BANK_W] ? '1 : bank_sum[BANK_W-1:0];

	assign idx_ext  = 32'(idx_q);
	assign idx_ok   = (idx_ext < 32'(MAX_FRAMES));
	assign waddr    = idx_ext[FW-1:0];
	assign delay_wr = given_q ? ((dms_q < MIN_DELAY_MS) ? MIN_DELAY_MS : dms_q)
	                          : DEFAULT_DELAY_MS;

	afs_ram #(
		.WIDTH(DELAY_W),
		.DEPTH(MAX_FRAMES)
	) u_delay_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(delay_wr),
		.raddr(raddr),
		.rdata(rdata)
	);

	afs_step #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_step (
		.bank      (bank_q),
		.delay     (rdata),
		.frame     (cur_q),
		.count     (count),
		.res       (step),
		.frame_next(frame_next)
	);

	always_comb begin
		state_n     = state_q;
		cur_n       = cur_q;
		bank_n      = bank_q;
		upl_frame_n = upl_frame_q;
		upl_valid_n = upl_valid_q;
		tex_n       = tex_q;
		steps_n     = steps_q;
		finish      = 1'b0;
		we          = 1'b0;
		raddr       = cur_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				steps_n = '0;
				case (op_q)
					OP_WRITE_DELAY: begin
						we     = idx_ok;
						finish = 1'b1;
					end
					OP_RESTART: begin
						cur_n       = '0;
						bank_n      = '0;
						upl_valid_n = 1'b0;
						finish      = 1'b1;
					end
					OP_UPLOADED: begin
						tex_n       = 1'b1;
						upl_frame_n = '0;
						upl_valid_n = 1'b1;
						finish      = 1'b1;
					end
					OP_TICK: begin
						if (animate) begin
							cur_n   = frame0;
							bank_n  = bank_sat;
							raddr   = frame0;
							state_n = ST_LOOP;
						end else begin
							finish = 1'b1;
						end
					end
					OP_RELEASE: begin
						tex_n       = 1'b0;
						cur_n       = '0;
						bank_n      = '0;
						upl_valid_n = 1'b0;
						finish      = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			ST_LOOP: begin
				// read data is the delay of cur_q; the next frame is fetched now
				if (step.hit) begin
					bank_n  = step.bank_rem;
					cur_n   = frame_next;
					steps_n = steps_q + SW'(1);
					raddr   = frame_next;
					finish  = (steps_q == LAST_STEP);
				end else begin
					finish = 1'b1;
				end
				if (finish) begin
					upl_frame_n = cur_n;
					upl_valid_n = 1'b1;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		if (finish) begin
			state_n = ST_IDLE;
		end
	end

	assign cur_ext   = 32'(cur_n);
	assign steps_ext = 32'(steps_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			bank_q      <= '0;
			upl_frame_q <= '0;
			upl_valid_q <= 1'b0;
			tex_q       <= 1'b0;
			steps_q     <= '0;
			fcount_q    <= FCOUNT_W'(1);
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_n;
			cur_q       <= cur_n;
			bank_q      <= bank_n;
			upl_frame_q <= upl_frame_n;
			upl_valid_q <= upl_valid_n;
			tex_q       <= tex_n;
			steps_q     <= steps_n;
			done_q      <= finish;
			if (cfg_valid && cfg_ready) begin
				fcount_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			idx_q     <= frame_index;
			given_q   <= delay_given;
			dms_q     <= delay_ms;
			elapsed_q <= elapsed_time;
		end
		if (finish) begin
			shown_q <= cur_ext[7:0];
			need_q  <= !upl_valid_n || (upl_frame_n != cur_n);
			adv_q   <= steps_ext[6:0];
		end
	end

	assign done            = done_q;
	assign shown_frame     = shown_q;
	assign upload_needed   = need_q;
	assign frames_advanced = adv_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> (steps_q <= LAST_STEP))
		else $error("step count beyond limit");

	a_tick_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (frames_advanced != 7'd0)) |-> !upload_needed)
		else $error("animating tick left frame unmarked");

	a_loop_animates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> (tex_q && (count > CW'(1))))
		else $error("frame walk without texture or frames");

endmodule

// ===== sim/frame_sequencer_scoreboard_pkg.sv =====
// Frame sequencer scoreboard: playback predictor and per-transaction result checks.
package frame_sequencer_scoreboard_pkg;
	import afs_pkg::*;

	class frame_sequencer_scoreboard;
		typedef struct packed {
			logic [7:0] frame;
			logic       need;
			logic [6:0] steps;
		} frame_report_t;

		logic [DELAY_W-1:0]  delay_mem [DEF_MAX_FRAMES];
		logic [7:0]          cur_frame;
		logic [BANK_W-1:0]   bank;
		logic [7:0]          up_frame;
		bit                  up_valid;
		bit                  texture;
		logic [FCOUNT_W-1:0] frame_count;

		frame_report_t expected_frames[$];
		int errors, items, animated, limited, saturated;

		function new();
			foreach (delay_mem[i])
				delay_mem[i] = '0;
			cur_frame   = '0;
			bank        = '0;
			up_frame    = '0;
			up_valid    = 1'b0;
			texture     = 1'b0;
			frame_count = FCOUNT_W'(1);
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		task flag_mismatch(string msg);
			if (errors < 100)
				$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// advance the predicted state by one accepted transaction
		function void apply_item(logic [2:0] op, logic [7:0] idx, logic given,
				logic [DELAY_W-1:0] dms, logic [ELAPSED_W-1:0] el);
			int count, frame, steps;
			logic [BANK_W:0]   sum;
			logic [BANK_W-1:0] cost;
			frame_report_t     exp_rep;
			steps = 0;
			count = (frame_count > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(frame_count);
			case (op)
				OP_WRITE_DELAY: begin
					if (!given)
						delay_mem[idx] = DEFAULT_DELAY_MS;
					else
						delay_mem[idx] = (dms < MIN_DELAY_MS) ? MIN_DELAY_MS : dms;
				end
				OP_RESTART: begin
					cur_frame = '0;
					bank      = '0;
					up_valid  = 1'b0;
				end
				OP_UPLOADED: begin
					texture  = 1'b1;
					up_frame = '0;
					up_valid = 1'b1;
				end
				OP_TICK: begin
					if (texture && count > 1) begin
						frame = int'(cur_frame);
						if (frame >= count)
							frame = 0;
						sum = {1'b0, bank} + (BANK_W+1)'(el);
						if (sum[BANK_W]) begin
							bank = '1;
							saturated++;
						end else begin
							bank = sum[BANK_W-1:0];
						end
						while (steps < DEF_MAX_STEPS) begin
							cost = BANK_W'(delay_mem[frame]) << FRAC_BITS;
							if (bank < cost)
								break;
							bank -= cost;
							frame++;
							if (frame >= count)
								frame = 0;
							steps++;
						end
						cur_frame = 8'(frame);
						if (!up_valid || up_frame != cur_frame) begin
							up_frame = cur_frame;
							up_valid = 1'b1;
						end
						animated++;
						if (steps == DEF_MAX_STEPS)
							limited++;
					end
				end
				OP_RELEASE: begin
					texture   = 1'b0;
					cur_frame = '0;
					bank      = '0;
					up_valid  = 1'b0;
				end
				default: ;
			endcase
			exp_rep.frame = cur_frame;
			exp_rep.need  = !up_valid || up_frame != cur_frame;
			exp_rep.steps = 7'(steps);
			expected_frames.push_back(exp_rep);
			items++;
		endfunction

		task check_report(logic [7:0] frame, logic need, logic [6:0] steps);
			frame_report_t exp_rep;
			if (expected_frames.size() == 0) begin
				flag_mismatch("result strobe with no transaction outstanding");
				return;
			end
			exp_rep = expected_frames.pop_front();
			if (frame !== exp_rep.frame)
				flag_mismatch($sformatf("shown_frame %0d, want %0d", frame, exp_rep.frame));
			if (need !== exp_rep.need)
				flag_mismatch($sformatf("upload_needed %0b, want %0b", need, exp_rep.need));
			if (steps !== exp_rep.steps)
				flag_mismatch($sformatf("frames_advanced %0d, want %0d", steps, exp_rep.steps));
		endtask
	endclass

endpackage

// ===== sim/testbench.sv =====
// Testbench for the animation frame sequencer core: stimulus, drivers and result monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import afs_pkg::*;
	import frame_sequencer_scoreboard_pkg::*;

	localparam logic [2:0] FIRST_UNUSED_OP = OP_RELEASE + 3'd1;
	localparam logic [2:0] LAST_UNUSED_OP  = '1;
	localparam logic [ELAPSED_W-1:0] MAX_ELAPSED = '1;
	localparam logic [DELAY_W-1:0]   MAX_DELAY   = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [2:0]           operation = '0;
	logic [7:0]           frame_index = '0;
	logic                 delay_given = 1'b0;
	logic [DELAY_W-1:0]   delay_ms = '0;
	logic [ELAPSED_W-1:0] elapsed_time = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [FCOUNT_W-1:0]  cfg_data = '0;
	logic                 done;
	logic [7:0]           shown_frame;
	logic                 upload_needed;
	logic [6:0]           frames_advanced;

	frame_sequencer_scoreboard sb = new();
	bit delay_loaded [DEF_MAX_FRAMES];
	int idle_pct = 0;
	int cfg_writes = 0;
	int phase_counts [10] = '{40, 3, 511, 256, 257, 255, 7, 2, 1, 16};

	animation_frame_sequencer_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.frame_index     (frame_index),
		.delay_given     (delay_given),
		.delay_ms        (delay_ms),
		.elapsed_time    (elapsed_time),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.shown_frame     (shown_frame),
		.upload_needed   (upload_needed),
		.frames_advanced (frames_advanced)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_report(shown_frame, upload_needed, frames_advanced);
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// mostly short delays so frames move; now and then clamp cases and huge ones
	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(9))
			0: return DELAY_W'($urandom_range(9));
			1: return DELAY_W'($urandom);
			2: return MAX_DELAY;
			default: return DELAY_W'($urandom_range(300, 10));
		endcase
	endfunction

	function automatic logic [ELAPSED_W-1:0] pick_elapsed();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return ELAPSED_W'($urandom_range(4095));
		else if (r < 80)
			return ELAPSED_W'($urandom_range(65535));
		else if (r < 95)
			return ELAPSED_W'($urandom);
		return MAX_ELAPSED;
	endfunction

	task automatic send(input logic [2:0] op, input logic [7:0] idx, input logic given,
			input logic [DELAY_W-1:0] dms, input logic [ELAPSED_W-1:0] el);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start     <= 1'b0;
			operation <= 3'($urandom);
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		frame_index  <= idx;
		delay_given  <= given;
		delay_ms     <= dms;
		elapsed_time <= el;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.apply_item(op, idx, given, dms, el);
		if (op == OP_WRITE_DELAY)
			delay_loaded[idx] = 1'b1;
	endtask

	task automatic tick(input logic [ELAPSED_W-1:0] el);
		send(OP_TICK, 8'($urandom), 1'($urandom), DELAY_W'($urandom), el);
	endtask

	task automatic control(input logic [2:0] op);
		send(op, 8'($urandom), 1'($urandom), DELAY_W'($urandom), ELAPSED_W'($urandom));
	endtask

	task automatic write_delay(input logic [7:0] idx, input logic given,
			input logic [DELAY_W-1:0] dms);
		send(OP_WRITE_DELAY, idx, given, dms, ELAPSED_W'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// register write with the block idle, then load any delay a tick could reach
	task automatic set_frames(input logic [FCOUNT_W-1:0] value);
		int reach;
		drain();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid      <= 1'b0;
		sb.frame_count = value;
		cfg_writes++;
		reach = (value > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(value);
		for (int i = 0; i < reach; i++) begin
			if (!delay_loaded[i])
				write_delay(8'(i), $urandom_range(3) != 0, pick_delay());
		end
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if ($urandom_range(49) == 0)
			drain();
		if (!sb.texture && r < 40)
			control(OP_UPLOADED);
		else if (r < 50)
			tick(pick_elapsed());
		else if (r < 65)
			write_delay(8'($urandom), $urandom_range(3) != 0, pick_delay());
		else if (r < 73)
			control(OP_UPLOADED);
		else if (r < 79)
			control(OP_RESTART);
		else if (r < 85)
			control(OP_RELEASE);
		else if (r < 90)
			control(3'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP)));
		else
			tick(pick_elapsed());
	endtask

	initial begin
		int tries;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single frame after reset: nothing may animate
		tick(MAX_ELAPSED);
		for (int k = 0; k < 3; k++)
			control(FIRST_UNUSED_OP + 3'(k));
		write_delay(8'd0, 1'b0, MAX_DELAY);
		write_delay(8'd1, 1'b1, '0);
		write_delay(8'd2, 1'b1, DELAY_W'(9));
		write_delay(8'd3, 1'b1, DELAY_W'(10));
		write_delay(8'd255, 1'b1, MAX_DELAY);
		control(OP_UPLOADED);
		tick(MAX_ELAPSED);
		control(OP_RELEASE);
		control(OP_RESTART);

		set_frames(FCOUNT_W'(4));
		tick(MAX_ELAPSED);
		control(OP_UPLOADED);
		tick('0);
		tick(ELAPSED_W'(DEFAULT_DELAY_MS) << FRAC_BITS);
		tick(MAX_ELAPSED);
		control(OP_RESTART);
		tick(ELAPSED_W'(1599));
		control(OP_RELEASE);

		// zero frames counts as one
		set_frames('0);
		control(OP_UPLOADED);
		tick(MAX_ELAPSED);

		// minimum delays and full ticks fill the bank to saturation
		set_frames(FCOUNT_W'(2));
		write_delay(8'd0, 1'b1, DELAY_W'(10));
		write_delay(8'd1, 1'b1, '0);
		control(OP_UPLOADED);
		for (int i = 0; i < 270; i++)
			tick(MAX_ELAPSED);

		// play deep into a long loop, then shrink the loop under the current frame
		idle_pct = 50;
		set_frames(FCOUNT_W'(40));
		control(OP_UPLOADED);
		tries = 0;
		while (sb.cur_frame < 10 && tries < 60) begin
			tick(MAX_ELAPSED);
			tries++;
		end
		set_frames(FCOUNT_W'(3));
		tick('0);
		tick(pick_elapsed());

		foreach (phase_counts[p]) begin
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 50;
				default: idle_pct = 14;
			endcase
			set_frames(FCOUNT_W'(phase_counts[p]));
			for (int i = 0; i < 70; i++)
				random_item();
		end

		drain();
		repeat (80) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag_mismatch("transactions still waiting for a result");
		$display("covered %0d transactions over %0d frame count settings",
			sb.items, cfg_writes);
		$display("%0d ticks animated, %0d hit the step limit, %0d saturated the bank",
			sb.animated, sb.limited, sb.saturated);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
